@@ rtl/smx_pkg.sv @@
`timescale 1ns / 1ps
package smx_pkg;

  localparam int ROW_W         = 11;
  localparam int COL_W         = 11;
  localparam int VALUE_W       = 64;
  localparam int ENTRY_TOTAL_W = 7;
  localparam int DIM_W         = 11;

  localparam logic [DIM_W-1:0] DIM_RESET = 11'd1024;

  typedef enum logic [1:0] {
    OP_ADD   = 2'd0,
    OP_SUB   = 2'd1,
    OP_READ  = 2'd2,
    OP_CLEAR = 2'd3
  } op_t;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  localparam logic REG_ROW_COUNT = 1'b0;
  localparam logic REG_COL_COUNT = 1'b1;

  typedef struct packed {
    logic [ROW_W-1:0]          row;
    logic [COL_W-1:0]          col;
    logic signed [VALUE_W-1:0] value;
  } entry_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0]  value;
    logic [ENTRY_TOTAL_W-1:0]   total;
    logic [1:0]                 status;
  } result_t;

endpackage

@@ rtl/smx_req_if.sv @@
`timescale 1ns / 1ps
interface smx_req_if;
  logic               valid;
  logic               ready;
  logic [1:0]         op;
  logic [10:0]        row;
  logic [10:0]        col;
  logic signed [63:0] value;

  modport source (output valid, output op, output row, output col, output value, input ready);
  modport sink (input valid, input op, input row, input col, input value, output ready);
endinterface

@@ rtl/smx_rsp_if.sv @@
`timescale 1ns / 1ps
interface smx_rsp_if;
  logic               valid;
  logic               ready;
  logic signed [63:0] result_value;
  logic [6:0]         entry_total;
  logic [1:0]         status;

  modport source (output valid, output result_value, output entry_total, output status,
                  input ready);
  modport sink (input valid, input result_value, input entry_total, input status,
                output ready);
endinterface

@@ rtl/sparse_matrix_accumulator.sv @@
// a search that misses reads every store entry in S_SCAN before S_UPDATE
// a hit at entry i ends the search early
// clear and out-of-range beats skip the scan and go straight to S_UPDATE
// one beat at a time, next beat taken the cycle after the result moves into the output register
// a result may wait in the output register while the next beat is taken
// reset: synchronous, active high; empties the store, dimensions return to 1024
`timescale 1ns / 1ps
module sparse_matrix_accumulator
  import smx_pkg::*;
#(
  parameter int CAPACITY = 64,
  parameter int MAX_DIM  = 1024
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic             wr_index,
  input  logic [DIM_W-1:0] wr_data,
  smx_req_if.sink          req,
  smx_rsp_if.source        rsp
);

  logic [DIM_W-1:0] row_count;
  logic [DIM_W-1:0] col_count;
  logic             res_valid;
  logic             res_ready;
  result_t          res;
  logic             out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_count <= DIM_RESET;
      col_count <= DIM_RESET;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_ROW_COUNT: row_count <= wr_data;
        REG_COL_COUNT: col_count <= wr_data;
        default:       row_count <= row_count;
      endcase
    end
  end

  smx_ctrl #(
    .CAPACITY (CAPACITY),
    .MAX_DIM  (MAX_DIM)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .row_count (row_count),
    .col_count (col_count),
    .req       (req),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  // output register
  assign res_ready = !out_valid || rsp.ready;
  assign rsp.valid = out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ready) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      rsp.result_value <= res.value;
      rsp.entry_total  <= res.total;
      rsp.status       <= res.status;
    end
  end

`ifndef SYNTHESIS
  a_ready_not_busy: assert property (@(posedge clk) disable iff (rst)
    req.ready |-> !res_valid)
    else $error("input ready while a result is pending");

  a_no_instant_result: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> !res_valid)
    else $error("result raised the cycle after acceptance");

  a_flagged_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.status != ST_OK) |-> (rsp.result_value == '0))
    else $error("flagged beat carries a nonzero value");
`endif

endmodule

@@ rtl/smx_store.sv @@
`timescale 1ns / 1ps
module smx_store
  import smx_pkg::*;
#(
  parameter int CAPACITY = 64,
  parameter int IW       = 6
) (
  input  logic          clk,
  input  logic          we,
  input  logic [IW-1:0] waddr,
  input  entry_t        wdata,
  input  logic [IW-1:0] raddr,
  output entry_t        rdata
);

  entry_t mem [CAPACITY];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/smx_ctrl.sv @@
`timescale 1ns / 1ps
module smx_ctrl
  import smx_pkg::*;
#(
  parameter int CAPACITY = 64,
  parameter int MAX_DIM  = 1024
) (
  input  logic             clk,
  input  logic             rst,
  input  logic [DIM_W-1:0] row_count,
  input  logic [DIM_W-1:0] col_count,
  smx_req_if.sink          req,
  output logic             res_valid,
  input  logic             res_ready,
  output result_t          res
);

  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [IW-1:0] LAST_IDX = IW'(CAPACITY - 1);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SCAN   = 4'b0010,
    S_UPDATE = 4'b0100,
    S_DONE   = 4'b1000
  } state_t;

  state_t state;

  op_t                       op_q;
  logic [ROW_W-1:0]          row_q;
  logic [COL_W-1:0]          col_q;
  logic signed [VALUE_W-1:0] amount;
  logic                      oor;
  logic [IW-1:0]             scan_idx;
  logic                      issue_done;
  logic                      pend_valid;
  logic [IW-1:0]             pend_idx;
  logic                      found;
  logic [IW-1:0]             slot;
  logic signed [VALUE_W-1:0] hit_value;
  logic                      free_found;
  logic [IW-1:0]             free_slot;
  logic [CAPACITY-1:0]       used;
  logic [CW-1:0]             count;

  entry_t                    rdata;
  logic                      we;
  logic [IW-1:0]             waddr;
  entry_t                    wdata;

  logic                      accept;
  logic                      row_ok;
  logic                      col_ok;
  logic                      hit;
  logic signed [VALUE_W-1:0] sum;
  logic [CW-1:0]             count_next;
  logic [CAPACITY-1:0]       used_next;
  logic [CW+ENTRY_TOTAL_W-1:0] total_ext;
  result_t                   res_next;

  assign req.ready = (state == S_IDLE);
  assign accept    = req.valid && req.ready;
  assign res_valid = (state == S_DONE);

  assign row_ok = (req.row != '0) && (req.row <= row_count) && (32'(req.row) <= MAX_DIM);
  assign col_ok = (req.col != '0) && (req.col <= col_count) && (32'(req.col) <= MAX_DIM);

  assign hit = pend_valid && used[pend_idx] && (rdata.row == row_q) && (rdata.col == col_q);

  // shared adder for the accumulate
  assign sum = hit_value + amount;

  smx_store #(
    .CAPACITY (CAPACITY),
    .IW       (IW)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (scan_idx),
    .rdata (rdata)
  );

  always_comb begin
    we              = 1'b0;
    waddr           = slot;
    wdata.row       = row_q;
    wdata.col       = col_q;
    wdata.value     = amount;
    count_next      = count;
    used_next       = used;
    res_next.value  = '0;
    res_next.status = ST_OK;
    if (op_q == OP_CLEAR) begin
      used_next  = '0;
      count_next = '0;
    end else if (oor) begin
      res_next.status = ST_RANGE;
    end else if (op_q == OP_READ || amount == '0) begin
      res_next.value = found ? hit_value : '0;
    end else if (found) begin
      we             = 1'b1;
      wdata.value    = sum;
      res_next.value = sum;
      if (sum == '0) begin
        used_next[slot] = 1'b0;
        count_next      = count - 1'b1;
      end
    end else if (free_found) begin
      we                   = 1'b1;
      waddr                = free_slot;
      used_next[free_slot] = 1'b1;
      count_next           = count + 1'b1;
      res_next.value       = amount;
    end else begin
      res_next.status = ST_FULL;
    end
    if (state != S_UPDATE) begin
      we = 1'b0;
    end
    total_ext      = {{ENTRY_TOTAL_W{1'b0}}, count_next};
    res_next.total = total_ext[ENTRY_TOTAL_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      used       <= '0;
      count      <= '0;
      pend_valid <= 1'b0;
      issue_done <= 1'b0;
      found      <= 1'b0;
      free_found <= 1'b0;
      scan_idx   <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            scan_idx   <= '0;
            issue_done <= 1'b0;
            pend_valid <= 1'b0;
            found      <= 1'b0;
            free_found <= 1'b0;
            if (op_t'(req.op) == OP_CLEAR || !row_ok || !col_ok) begin
              state <= S_UPDATE;
            end else begin
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (!issue_done) begin
            if (scan_idx == LAST_IDX) begin
              issue_done <= 1'b1;
            end else begin
              scan_idx <= scan_idx + 1'b1;
            end
          end
          if (hit) begin
            found      <= 1'b1;
            pend_valid <= 1'b0;
            state      <= S_UPDATE;
          end else begin
            if (pend_valid && !used[pend_idx] && !free_found) begin
              free_found <= 1'b1;
            end
            if (pend_valid && pend_idx == LAST_IDX) begin
              pend_valid <= 1'b0;
              state      <= S_UPDATE;
            end else begin
              pend_valid <= !issue_done;
            end
          end
        end
        S_UPDATE: begin
          used  <= used_next;
          count <= count_next;
          state <= S_DONE;
        end
        S_DONE: begin
          if (res_ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (accept) begin
      op_q   <= op_t'(req.op);
      row_q  <= req.row;
      col_q  <= req.col;
      amount <= (op_t'(req.op) == OP_SUB) ? -req.value : req.value;
      oor    <= !row_ok || !col_ok;
    end
    if (state == S_SCAN) begin
      pend_idx <= scan_idx;
      if (hit) begin
        slot      <= pend_idx;
        hit_value <= rdata.value;
      end
      if (pend_valid && !used[pend_idx] && !free_found) begin
        free_slot <= pend_idx;
      end
    end
    if (state == S_UPDATE) begin
      res <= res_next;
    end
  end

endmodule

@@ verif/sparse_matrix_accumulator_tb.sv @@
`timescale 1ns / 1ps
module sparse_matrix_accumulator_tb;
  import smx_pkg::*;

  localparam int STORE_DEPTH = 64;
  localparam int DIM_MAX     = 1024;
  localparam int CYCLE_LIMIT = 1000000;

  typedef struct {
    op_t                 op;
    logic [ROW_W-1:0]    row;
    logic [COL_W-1:0]    col;
    logic signed [63:0]  value;
    bit                  hold;
  } matrix_op_t;

  logic clk;
  logic rst;
  logic wr_en;
  logic wr_index;
  logic [DIM_W-1:0] wr_data;

  smx_req_if req_ch ();
  smx_rsp_if rsp_ch ();

  sparse_matrix_accumulator DUT (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .req      (req_ch),
    .rsp      (rsp_ch)
  );

  // mirror of the store
  logic [DIM_W-1:0] dim_rows;
  logic [DIM_W-1:0] dim_cols;
  logic [ROW_W-1:0] held_row [STORE_DEPTH];
  logic [COL_W-1:0] held_col [STORE_DEPTH];
  logic [63:0]      held_sum [STORE_DEPTH];
  bit               held_used [STORE_DEPTH];
  int unsigned      held_count;

  matrix_op_t pending_ops [$];
  result_t    due_results [$];
  matrix_op_t cur_op;
  bit         drv_busy;
  bit         req_fire;
  int         gap_left;
  int         burst_left;
  int         rcv_tick;
  int         rcv_mode;
  int         fail_count;
  int         cycle_count;

  initial clk = 1'b0;
  always #2 clk = ~clk;

  function automatic void wipe_store();
    for (int i = 0; i < STORE_DEPTH; i++) begin
      held_used[i] = 1'b0;
      held_sum[i]  = '0;
      held_row[i]  = '0;
      held_col[i]  = '0;
    end
    held_count = 0;
  endfunction

  function automatic bit pos_ok(logic [DIM_W-1:0] p, logic [DIM_W-1:0] lim);
    int top;
    top = (lim < DIM_MAX) ? lim : DIM_MAX;
    return (p >= 1) && (p <= top);
  endfunction

  function automatic result_t apply_matrix_op(matrix_op_t it);
    result_t     r;
    int          hit;
    int          free_slot;
    logic [63:0] amt;
    logic [63:0] sum;
    r.value  = '0;
    r.status = ST_OK;
    hit      = -1;
    free_slot = -1;
    if (it.op == OP_CLEAR) begin
      wipe_store();
    end else if (!pos_ok(it.row, dim_rows) || !pos_ok(it.col, dim_cols)) begin
      r.status = ST_RANGE;
    end else begin
      for (int i = 0; i < STORE_DEPTH; i++)
        if (hit < 0 && held_used[i] && held_row[i] == it.row && held_col[i] == it.col)
          hit = i;
      amt = it.value;
      if (it.op == OP_SUB) amt = 64'd0 - amt;
      if (it.op == OP_READ || amt == 64'd0) begin
        if (hit >= 0) r.value = held_sum[hit];
      end else if (hit >= 0) begin
        sum = held_sum[hit] + amt;
        held_sum[hit] = sum;
        r.value = sum;
        if (sum == 64'd0) begin
          held_used[hit] = 1'b0;
          held_count--;
        end
      end else begin
        for (int i = 0; i < STORE_DEPTH; i++)
          if (free_slot < 0 && !held_used[i]) free_slot = i;
        if (free_slot < 0) begin
          r.status = ST_FULL;
        end else begin
          held_used[free_slot] = 1'b1;
          held_row[free_slot]  = it.row;
          held_col[free_slot]  = it.col;
          held_sum[free_slot]  = amt;
          held_count++;
          r.value = amt;
        end
      end
    end
    r.total = held_count[ENTRY_TOTAL_W-1:0];
    return r;
  endfunction

  // sample at the rising edge
  always @(posedge clk) begin
    matrix_op_t seen;
    result_t    want;
    cycle_count++;
    req_fire = 1'b0;
    if (!rst) begin
      if (wr_en) begin
        if (wr_index == REG_ROW_COUNT) dim_rows = wr_data;
        else dim_cols = wr_data;
      end
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (due_results.size() == 0) begin
          $display("%0t: unexpected result value %h total %0d status %0d", $time,
                   rsp_ch.result_value, rsp_ch.entry_total, rsp_ch.status);
          fail_count++;
        end else begin
          want = due_results.pop_front();
          if (rsp_ch.result_value !== want.value || rsp_ch.entry_total !== want.total ||
              rsp_ch.status !== want.status) begin
            $display("%0t: expected value %h total %0d status %0d, got value %h total %0d status %0d",
                     $time, want.value, want.total, want.status,
                     rsp_ch.result_value, rsp_ch.entry_total, rsp_ch.status);
            fail_count++;
          end
        end
      end
      if (req_ch.valid && req_ch.ready) begin
        req_fire   = 1'b1;
        seen.op    = op_t'(req_ch.op);
        seen.row   = req_ch.row;
        seen.col   = req_ch.col;
        seen.value = req_ch.value;
        seen.hold  = 1'b0;
        due_results.push_back(apply_matrix_op(seen));
      end
    end
  end

  always @(posedge clk) begin
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // drive at the falling edge
  always @(negedge clk) begin
    if (!rst) begin
      if (drv_busy && req_fire) drv_busy = 1'b0;
      if (!drv_busy) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_ops.size() != 0 &&
                     (!pending_ops[0].hold || due_results.size() == 0)) begin
          cur_op   = pending_ops.pop_front();
          drv_busy = 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 25);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
          end
        end
      end
      req_ch.valid <= drv_busy;
      if (drv_busy) begin
        req_ch.op    <= cur_op.op;
        req_ch.row   <= cur_op.row;
        req_ch.col   <= cur_op.col;
        req_ch.value <= cur_op.value;
      end
      rcv_tick++;
      if (rcv_tick % 400 == 0) rcv_mode = $urandom_range(0, 3);
      case (rcv_mode)
        0: rsp_ch.ready <= 1'b1;
        1: rsp_ch.ready <= 1'($urandom_range(0, 1));
        2: rsp_ch.ready <= (rcv_tick % 7) < 4;
        default: rsp_ch.ready <= (rcv_tick % 37) > 25;
      endcase
    end
  end

  task automatic push_op(op_t o, int r, int c, logic [63:0] v, bit h);
    matrix_op_t it;
    it.op    = o;
    it.row   = ROW_W'(r);
    it.col   = COL_W'(c);
    it.value = v;
    it.hold  = h;
    pending_ops.push_back(it);
  endtask

  function automatic logic [63:0] pick_amount();
    logic [63:0] v;
    case ($urandom_range(0, 9))
      0: v = 64'd0;
      1: v = 64'h8000_0000_0000_0000;
      2: v = 64'h7FFF_FFFF_FFFF_FFFF;
      3, 4: v = {$urandom, $urandom};
      5: v = '1;
      default: begin
        v = 64'($urandom_range(1, 3));
        if ($urandom_range(0, 1)) v = 64'd0 - v;
      end
    endcase
    return v;
  endfunction

  function automatic int pick_pos(int top);
    if (top == 0) return $urandom_range(0, 2047);
    return $urandom_range(1, top);
  endfunction

  task automatic queue_random_ops(int n, int rows, int cols, int clear_pm, int pool_pct);
    matrix_op_t pool [12];
    matrix_op_t recent [$];
    matrix_op_t it;
    int top_r;
    int top_c;
    int k;
    top_r = (rows > DIM_MAX) ? DIM_MAX : rows;
    top_c = (cols > DIM_MAX) ? DIM_MAX : cols;
    for (int i = 0; i < 12; i++) begin
      pool[i].row = ROW_W'(pick_pos(top_r));
      pool[i].col = COL_W'(pick_pos(top_c));
    end
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(0, 999);
      it.value = pick_amount();
      if (k < clear_pm) begin
        it.op  = OP_CLEAR;
        it.row = ROW_W'($urandom_range(0, 2047));
        it.col = COL_W'($urandom_range(0, 2047));
      end else if (recent.size() != 0 && $urandom_range(0, 4) == 0) begin
        // undo an earlier update so that entries get deleted
        it    = recent[$urandom_range(0, recent.size() - 1)];
        it.op = (it.op == OP_ADD) ? OP_SUB : OP_ADD;
      end else begin
        k = $urandom_range(0, 99);
        it.op = (k < 45) ? OP_ADD : ((k < 70) ? OP_SUB : OP_READ);
        k = $urandom_range(0, 99);
        if (k < pool_pct) begin
          k = $urandom_range(0, 11);
          it.row = pool[k].row;
          it.col = pool[k].col;
        end else if (k < 92) begin
          it.row = ROW_W'(pick_pos(top_r));
          it.col = COL_W'(pick_pos(top_c));
        end else begin
          it.row = ROW_W'($urandom_range(0, 2047));
          it.col = COL_W'($urandom_range(0, 2047));
        end
        if (it.op != OP_READ) begin
          recent.push_back(it);
          if (recent.size() > 16) void'(recent.pop_front());
        end
      end
      it.hold = ($urandom_range(0, 99) == 0);
      pending_ops.push_back(it);
    end
  endtask

  task automatic wait_drained();
    while (pending_ops.size() != 0 || drv_busy || due_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, int data);
    @(negedge clk);
    wr_en    <= 1'b1;
    wr_index <= idx;
    wr_data  <= DIM_W'(data);
    @(negedge clk);
    wr_en    <= 1'b0;
  endtask

  task automatic run_phase(int rows, int cols, int n, int clear_pm, int pool_pct);
    wait_drained();
    write_reg(REG_ROW_COUNT, rows);
    write_reg(REG_COL_COUNT, cols);
    queue_random_ops(n, rows, cols, clear_pm, pool_pct);
  endtask

  initial begin
    rst          = 1'b1;
    wr_en        = 1'b0;
    wr_index     = REG_ROW_COUNT;
    wr_data      = '0;
    req_ch.valid = 1'b0;
    req_ch.op    = OP_ADD;
    req_ch.row   = '0;
    req_ch.col   = '0;
    req_ch.value = '0;
    rsp_ch.ready = 1'b0;
    drv_busy     = 1'b0;
    req_fire     = 1'b0;
    gap_left     = 0;
    burst_left   = 0;
    rcv_tick     = 0;
    rcv_mode     = 0;
    fail_count   = 0;
    cycle_count  = 0;
    dim_rows     = DIM_RESET;
    dim_cols     = DIM_RESET;
    wipe_store();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed, dimensions at reset
    push_op(OP_ADD, 1, 1, 64'h7FFF_FFFF_FFFF_FFFF, 0);
    push_op(OP_READ, 1, 1, 64'd0, 0);
    push_op(OP_ADD, 1, 1, 64'd1, 0);
    push_op(OP_ADD, 1024, 1024, 64'h8000_0000_0000_0000, 0);
    push_op(OP_SUB, 1, 2, 64'h8000_0000_0000_0000, 0);
    push_op(OP_ADD, 1, 1, 64'd0, 0);
    push_op(OP_SUB, 1, 2, 64'd0, 0);
    push_op(OP_READ, 5, 5, 64'd9, 0);
    push_op(OP_ADD, 0, 1, 64'd5, 0);
    push_op(OP_ADD, 1, 0, 64'd5, 0);
    push_op(OP_READ, 1025, 3, 64'd0, 0);
    push_op(OP_SUB, 3, 1025, 64'd4, 0);
    push_op(OP_ADD, 2047, 2047, '1, 0);
    push_op(OP_READ, 0, 0, 64'd0, 0);
    push_op(OP_SUB, 1, 1, 64'h8000_0000_0000_0000, 0);
    push_op(OP_READ, 1, 1, 64'd0, 0);
    push_op(OP_ADD, 2, 2, '1, 0);
    push_op(OP_ADD, 2, 2, 64'd1, 0);
    push_op(OP_ADD, 1023, 1, 64'h5555_5555_5555_5555, 0);
    push_op(OP_ADD, 1, 1023, 64'hAAAA_AAAA_AAAA_AAAA, 0);
    push_op(OP_CLEAR, 2047, 2047, '1, 0);
    push_op(OP_READ, 1024, 1024, 64'd0, 1);
    push_op(OP_ADD, 512, 512, 64'd3, 0);

    run_phase(9, 9, 400, 4, 10);
    run_phase(1024, 1024, 400, 15, 70);
    run_phase(0, 2047, 40, 20, 50);
    run_phase(1, 1, 60, 20, 50);
    run_phase(2047, 3, 300, 15, 60);
    run_phase(33, 1024, 200, 10, 60);

    wait_drained();
    repeat (80) @(posedge clk);
    if (fail_count == 0 && due_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
